// ===== rtl/core/yrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared types and constants for the YUYV to RGB converter with overlay.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  // Width of the chroma products: an 8-bit signed chroma times a 9-bit
  // coefficient stays within 18 signed bits.
  localparam int PROD_W = 18;

  localparam logic signed [PROD_W-1:0] COEF_RV = 18'sd359;
  localparam logic signed [PROD_W-1:0] COEF_GU = 18'sd88;
  localparam logic signed [PROD_W-1:0] COEF_GV = 18'sd183;
  localparam logic signed [PROD_W-1:0] COEF_BU = 18'sd453;

  localparam logic signed [9:0] GOFF_MAX = 10'sd126;
  localparam logic signed [9:0] GOFF_MIN = -10'sd126;

  // Pixel position inside one macropixel
  localparam logic [1:0] PIX_FIRST = 2'd0;
  localparam logic [1:0] PIX_MID   = 2'd1;
  localparam logic [1:0] PIX_LAST  = 2'd2;

  // One macropixel after the chroma terms are resolved
  typedef struct packed {
    logic [7:0]               y0;
    logic [7:0]               ymid;
    logic [7:0]               y1;
    logic signed [8:0]        r_off;
    logic signed [7:0]        g_off;
    logic signed [8:0]        b_off;
    logic [2:0][23:0]         ovl;    // [0] first, [1] middle, [2] last
  } chroma_item_t;

  // Saturate a widened channel sum to 0..255
  function automatic logic [7:0] sat8(input logic signed [9:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/yuyv_to_rgb_overlay.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb_overlay
// YUYV to RGB converter with 1.5x horizontal stretch and overlay pass-through.
// ----------------------------------------------------------------------------
// Each input beat carries one YUYV macropixel and three overlay pixels; the
// block returns three RGB beats for it, built from the lumas Y0, the average
// (Y0>>1)+(Y1>>1) and Y1, with out_tlast on the third. The output channel
// moves one pixel per cycle while out_tready is high, so the sustained
// macropixel rate is set by the single-pixel output register. A macropixel
// passes through two chroma stages (products, then scaling and green
// clamp), a serializer that holds it while its three pixels go out, and the
// output register where the final add, clamp and overlay select land. The
// next macropixel is taken while the previous one is still being serialized,
// and back-pressure on out_tready stalls each stage once all the stages
// after it are full. With overlay enabled, an overlay pixel with any channel
// at 32 or above replaces the converted one.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_overlay (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // overlay_enable
  // input macropixel stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // from bit 0: luma_first[7:0], chroma_blue[15:8], luma_second[23:16],
  // chroma_red[31:24], overlay_first_pixel[55:32],
  // overlay_middle_pixel[79:56], overlay_last_pixel[103:80]
  input  logic [103:0] in_tdata,
  // output pixel stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // from bit 0: red[7:0], green[15:8], blue[23:16]
  output logic [23:0]  out_tdata,
  output logic         out_tlast      // last_of_run
);
  import yrgb_pkg::*;

  logic         ovl_en_r;

  logic         chr_valid;
  logic         chr_ready;
  chroma_item_t chr_item;

  // serializer
  logic         ser_v_r, ser_v_nxt;
  logic [1:0]   ser_idx_r, ser_idx_nxt;
  chroma_item_t ser_r;
  logic         ser_emit, ser_load;

  // output register
  logic         out_v_r, out_v_nxt, out_adv;
  logic [23:0]  out_data_r, out_data_nxt;
  logic         out_last_r, out_last_nxt;

  logic [7:0]        luma;
  logic [23:0]       ovl_px;
  logic signed [9:0] luma_w;
  logic              ovl_hit;

  // Hold the overlay enable; it is to be written only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      ovl_en_r <= cfg_wr_data;
    end
  end

  yrgb_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (chr_valid),
    .dn_ready (chr_ready),
    .dn_item  (chr_item)
  );

  // Advance the output register when it is empty or its beat is taken
  assign out_adv  = !out_v_r || out_tready;
  assign ser_emit = ser_v_r && out_adv;
  // Take a new macropixel when empty or as the last pixel leaves
  assign chr_ready = !ser_v_r || (ser_emit && (ser_idx_r == PIX_LAST));
  assign ser_load  = chr_ready && chr_valid;

  always_comb begin
    ser_v_nxt   = ser_v_r;
    ser_idx_nxt = ser_idx_r;
    if (chr_ready) begin
      ser_v_nxt   = chr_valid;
      ser_idx_nxt = PIX_FIRST;
    end else if (ser_emit) begin
      ser_idx_nxt = ser_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_idx_r <= PIX_FIRST;
    end else begin
      ser_v_r   <= ser_v_nxt;
      ser_idx_r <= ser_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_r <= chr_item;
    end
  end

  // Pick the luma and overlay pixel for the current position
  always_comb begin
    case (ser_idx_r)
      PIX_FIRST: begin
        luma   = ser_r.y0;
        ovl_px = ser_r.ovl[0];
      end
      PIX_MID: begin
        luma   = ser_r.ymid;
        ovl_px = ser_r.ovl[1];
      end
      PIX_LAST: begin
        luma   = ser_r.y1;
        ovl_px = ser_r.ovl[2];
      end
      default: begin
        luma   = ser_r.y0;
        ovl_px = ser_r.ovl[0];
      end
    endcase
  end

  assign luma_w = signed'({2'b00, luma});
  // A channel at 32 or above has one of its top three bits set
  assign ovl_hit = ovl_en_r &&
                   ((|ovl_px[23:21]) || (|ovl_px[15:13]) || (|ovl_px[7:5]));

  always_comb begin
    if (ovl_hit) begin
      // overlay is red<<16 | green<<8 | blue; tdata puts red lowest
      out_data_nxt = {ovl_px[7:0], ovl_px[15:8], ovl_px[23:16]};
    end else begin
      out_data_nxt = {sat8(luma_w + 10'(ser_r.b_off)),
                      sat8(luma_w - 10'(ser_r.g_off)),
                      sat8(luma_w + 10'(ser_r.r_off))};
    end
    out_last_nxt = (ser_idx_r == PIX_LAST);
    out_v_nxt    = out_adv ? ser_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_emit) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A held macropixel never points past its last pixel
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_v_r |-> (ser_idx_r != 2'd3))
    else $error("serializer position out of range");

  // A stalled serializer keeps its position
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_v_r && !out_adv) |=> (ser_v_r && $stable(ser_idx_r)))
    else $error("serializer position moved during stall");

  // Each emitted pixel shows up with tlast matching its position
  a_tlast_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ser_emit |=> (out_tvalid && (out_tlast == ($past(ser_idx_r) == PIX_LAST))))
    else $error("tlast does not match pixel position");

  // A new macropixel starts at the first pixel
  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    ser_load |=> (ser_v_r && (ser_idx_r == PIX_FIRST)))
    else $error("macropixel loaded at wrong position");

endmodule

// ===== rtl/core/yrgb_chroma.sv =====
// ----------------------------------------------------------------------------
// yrgb_chroma
// Two-stage pipeline: chroma products, then floor scaling and green clamp.
// ----------------------------------------------------------------------------
module yrgb_chroma (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [103:0]          up_data,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output yrgb_pkg::chroma_item_t dn_item
);
  import yrgb_pkg::*;

  typedef struct packed {
    logic [7:0]               y0;
    logic [7:0]               y1;
    logic signed [PROD_W-1:0] p_rv;
    logic signed [PROD_W-1:0] p_gu;
    logic signed [PROD_W-1:0] p_gv;
    logic signed [PROD_W-1:0] p_bu;
    logic [2:0][23:0]         ovl;
  } prod_item_t;

  logic               s1_v_r, s1_v_nxt, s1_en;
  logic               s2_v_r, s2_v_nxt, s2_en;
  prod_item_t         s1_r, s1_nxt;
  chroma_item_t       s2_r, s2_nxt;

  logic signed [7:0]        u_s, v_s;
  logic signed [PROD_W-1:0] u_e, v_e;
  logic signed [9:0]        g_sum;

  assign s2_en    = !s2_v_r || dn_ready;
  assign s1_en    = !s1_v_r || s2_en;
  assign up_ready = s1_en;

  // Remove the 128 bias by flipping the top bit
  assign u_s = signed'({~up_data[15], up_data[14:8]});
  assign v_s = signed'({~up_data[31], up_data[30:24]});
  assign u_e = PROD_W'(u_s);
  assign v_e = PROD_W'(v_s);

  always_comb begin
    s1_nxt.y0   = up_data[7:0];
    s1_nxt.y1   = up_data[23:16];
    s1_nxt.p_rv = v_e * COEF_RV;
    s1_nxt.p_gu = u_e * COEF_GU;
    s1_nxt.p_gv = v_e * COEF_GV;
    s1_nxt.p_bu = u_e * COEF_BU;
    s1_nxt.ovl  = up_data[103:32];
  end

  // Arithmetic shift by 8 is the floor division by 256
  assign g_sum = signed'(s1_r.p_gu[17:8]) + signed'(s1_r.p_gv[17:8]);

  always_comb begin
    s2_nxt.y0    = s1_r.y0;
    s2_nxt.y1    = s1_r.y1;
    s2_nxt.ymid  = {1'b0, s1_r.y0[7:1]} + {1'b0, s1_r.y1[7:1]};
    s2_nxt.r_off = signed'(s1_r.p_rv[16:8]);
    s2_nxt.b_off = signed'(s1_r.p_bu[16:8]);
    if (g_sum > GOFF_MAX) begin
      s2_nxt.g_off = GOFF_MAX[7:0];
    end else if (g_sum < GOFF_MIN) begin
      s2_nxt.g_off = GOFF_MIN[7:0];
    end else begin
      s2_nxt.g_off = g_sum[7:0];
    end
    s2_nxt.ovl   = s1_r.ovl;
  end

  assign s1_v_nxt = s1_en ? up_valid : s1_v_r;
  assign s2_v_nxt = s2_en ? s1_v_r : s2_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_r <= s1_nxt;
    end
    if (s2_en) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_v_r;
  assign dn_item  = s2_r;

endmodule
